/* rtl/swpg_pkg.sv */
// shared types and constants for the stereo width, pan and gain core
`default_nettype none
package swpg_pkg;

  localparam int SAMPLE_BITS = 24;

  localparam int WIDTH_BITS = 16;
  localparam int GAIN_BITS  = 16;
  localparam int PAN_BITS   = 17;
  localparam int PG_BITS    = 17;

  localparam int FRAC_SHIFT   = 14;
  localparam int ROUND1_SHIFT = 16;
  localparam int ROUND2_SHIFT = 28;

  localparam int SUM_W = SAMPLE_BITS + 16;
  localparam int MAG_W = SAMPLE_BITS + 15;
  localparam int P1_W  = MAG_W + PG_BITS;
  localparam int T1_W  = P1_W + 1 - ROUND1_SHIFT;
  localparam int P2_W  = T1_W + GAIN_BITS;
  localparam int T2_W  = P2_W + 1 - ROUND2_SHIFT;
  localparam int EXT_W = SUM_W - SAMPLE_BITS - FRAC_SHIFT;

  localparam int LANE_STAGES = 4;

  localparam int DATA_W = ((2 * SAMPLE_BITS + 7) / 8) * 8;

  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  localparam int SQ_IN_W  = 34;
  localparam int SQ_OUT_W = 17;
  localparam int SQ_STEPS = 17;
  localparam int SQ_REM_W = 19;
  localparam int SQ_CNT_W = 5;

  localparam logic [PAN_BITS-1:0]   PAN_ONE      = 17'd65536;
  localparam logic [PAN_BITS-1:0]   PAN_RESET    = 17'd32768;
  localparam logic [PG_BITS-1:0]    PG_ONE       = 17'd65536;
  localparam logic [PG_BITS-1:0]    PG_TOL       = 17'd6;
  localparam logic [GAIN_BITS-1:0]  GAIN_ONE     = 16'd16384;
  localparam logic [GAIN_BITS-1:0]  GAIN_TOL     = 16'd1;
  localparam logic [WIDTH_BITS-1:0] WIDTH_RESET  = 16'd0;
  localparam logic [WIDTH_BITS-1:0] WIDTH_POS1   = 16'h0001;
  localparam logic [WIDTH_BITS-1:0] WIDTH_NEG1   = 16'hffff;

  localparam logic [P1_W:0] RND1_HALF = (P1_W + 1)'(1) << (ROUND1_SHIFT - 1);
  localparam logic [P2_W:0] RND2_HALF = (P2_W + 1)'(1) << (ROUND2_SHIFT - 1);

  localparam logic [T2_W-1:0] POS_LIMIT =
    T2_W'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
  localparam logic [T2_W-1:0] NEG_LIMIT = T2_W'(64'd1 << (SAMPLE_BITS - 1));

  localparam logic [SAMPLE_BITS-1:0] SAT_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic [SAMPLE_BITS-1:0] SAT_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  typedef enum logic [1:0] {
    REG_WIDTH = 2'd0,
    REG_GAIN  = 2'd1,
    REG_PAN   = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample;
    logic                   sat;
  } lane_res_t;

endpackage
`default_nettype wire

/* rtl/swpg_sqrt.sv */
// bit-serial rounded square root for one pan gain
`default_nettype none
module swpg_sqrt (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [swpg_pkg::SQ_IN_W-1:0] radicand_i,
  output logic                         busy_o,
  output logic [swpg_pkg::SQ_OUT_W-1:0] root_o
);
  import swpg_pkg::*;

  logic [SQ_IN_W-1:0]  rad_q, rad_d;
  logic [SQ_REM_W-1:0] rem_q, rem_d;
  logic [SQ_OUT_W-1:0] root_q, root_d;
  logic [SQ_CNT_W-1:0] cnt_q, cnt_d;

  logic [SQ_REM_W+1:0] rem_next;
  logic [SQ_REM_W+1:0] trial;

  always_comb begin
    rem_next = {rem_q, rad_q[SQ_IN_W-1 -: 2]};
    trial    = (SQ_REM_W + 2)'({root_q, 2'b01});
    rad_d    = rad_q;
    rem_d    = rem_q;
    root_d   = root_q;
    cnt_d    = cnt_q;
    if (start_i) begin
      rad_d  = radicand_i;
      rem_d  = '0;
      root_d = '0;
      cnt_d  = SQ_CNT_W'(SQ_STEPS);
    end else if (cnt_q != '0) begin
      rad_d = {rad_q[SQ_IN_W-3:0], 2'b00};
      cnt_d = cnt_q - 1'b1;
      if (rem_next >= trial) begin
        rem_d  = SQ_REM_W'(rem_next - trial);
        root_d = {root_q[SQ_OUT_W-2:0], 1'b1};
      end else begin
        rem_d  = SQ_REM_W'(rem_next);
        root_d = {root_q[SQ_OUT_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rad_q  <= '0;
      rem_q  <= '0;
      root_q <= PG_ONE;
      cnt_q  <= '0;
    end else begin
      rad_q  <= rad_d;
      rem_q  <= rem_d;
      root_q <= root_d;
      cnt_q  <= cnt_d;
    end
  end

  // round to nearest: remainder above root means the fraction is at least one half
  assign busy_o = (cnt_q != '0);
  assign root_o = root_q + SQ_OUT_W'(rem_q > SQ_REM_W'(root_q));

`ifndef NO_ASSERTIONS
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= SQ_CNT_W'(SQ_STEPS))
    else $error("sqrt step count out of range");

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o |-> (rem_q <= SQ_REM_W'({root_q, 1'b0})))
    else $error("sqrt remainder exceeds twice the root");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> busy_o)
    else $error("sqrt not busy after start");
`endif

endmodule
`default_nettype wire

/* rtl/swpg_lane.sv */
// one channel lane: cross-feed, pan gain, output gain, round and saturate
`default_nettype none
module swpg_lane (
  input  logic                                  clk_i,
  input  logic                                  en_i,
  input  logic signed [swpg_pkg::SAMPLE_BITS-1:0] self_i,
  input  logic signed [swpg_pkg::SAMPLE_BITS-1:0] other_i,
  input  logic signed [swpg_pkg::WIDTH_BITS-1:0]  width_i,
  input  logic [swpg_pkg::PG_BITS-1:0]          pan_gain_i,
  input  logic [swpg_pkg::GAIN_BITS-1:0]        gain_i,
  input  logic                                  bypass_i,
  output swpg_pkg::lane_res_t                   res_o
);
  import swpg_pkg::*;

  logic signed [SUM_W-1:0]       prod_d, prod_q;
  logic signed [SAMPLE_BITS-1:0] self1_q, self2_q, self3_q, self4_q;
  logic signed [SUM_W-1:0]       sum_d;
  logic [SUM_W-1:0]              neg_sum;
  logic [MAG_W-1:0]              mag_d, mag_q;
  logic                          neg2_q, neg3_q, neg4_q;
  logic [P1_W-1:0]               p1_d, p1_q;
  logic [P1_W:0]                 rnd1;
  logic [T1_W-1:0]               t1;
  logic [P2_W-1:0]               p2_d, p2_q;
  logic [P2_W:0]                 rnd2;
  logic [T2_W-1:0]               t2;
  logic [SAMPLE_BITS-1:0]        mag_lo;

  always_comb begin
    prod_d  = other_i * width_i;
    sum_d   = $signed({{EXT_W{self1_q[SAMPLE_BITS-1]}}, self1_q, {FRAC_SHIFT{1'b0}}})
              + prod_q;
    neg_sum = -sum_d;
    mag_d   = sum_d[SUM_W-1] ? neg_sum[MAG_W-1:0] : sum_d[MAG_W-1:0];
    p1_d    = P1_W'(mag_q) * P1_W'(pan_gain_i);
    rnd1    = {1'b0, p1_q} + RND1_HALF;
    t1      = rnd1[P1_W:ROUND1_SHIFT];
    p2_d    = P2_W'(t1) * P2_W'(gain_i);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q  <= prod_d;
      self1_q <= self_i;
      mag_q   <= mag_d;
      neg2_q  <= sum_d[SUM_W-1];
      self2_q <= self1_q;
      p1_q    <= p1_d;
      neg3_q  <= neg2_q;
      self3_q <= self2_q;
      p2_q    <= p2_d;
      neg4_q  <= neg3_q;
      self4_q <= self3_q;
    end
  end

  always_comb begin
    rnd2   = {1'b0, p2_q} + RND2_HALF;
    t2     = rnd2[P2_W:ROUND2_SHIFT];
    mag_lo = t2[SAMPLE_BITS-1:0];
    res_o.sat    = 1'b0;
    res_o.sample = self4_q;
    if (!bypass_i) begin
      if (!neg4_q) begin
        if (t2 > POS_LIMIT) begin
          res_o.sat    = 1'b1;
          res_o.sample = SAT_MAX;
        end else begin
          res_o.sample = mag_lo;
        end
      end else begin
        if (t2 > NEG_LIMIT) begin
          res_o.sat    = 1'b1;
          res_o.sample = SAT_MIN;
        end else begin
          res_o.sample = ~mag_lo + 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/swpg_merge.sv */
// joins the two lanes into one result beat behind an output register and skid slot
`default_nettype none
module swpg_merge (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          pipe_valid_i,
  input  swpg_pkg::lane_res_t           left_i,
  input  swpg_pkg::lane_res_t           right_i,
  output logic                          en_o,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [swpg_pkg::DATA_W-1:0]   m_axis_tdata,  // left_out, right_out
  output logic                          m_axis_tuser   // clipped
);
  import swpg_pkg::*;

  logic                   out_v_q, out_v_d;
  logic                   skid_v_q, skid_v_d;
  logic [SAMPLE_BITS-1:0] out_l_q, out_r_q, skid_l_q, skid_r_q;
  logic                   out_c_q, skid_c_q;
  logic                   in_fire, out_free;

  assign en_o     = !skid_v_q;
  assign in_fire  = pipe_valid_i && !skid_v_q;
  assign out_free = !out_v_q || m_axis_tready;

  always_comb begin
    out_v_d  = out_v_q;
    skid_v_d = skid_v_q;
    if (out_free) begin
      out_v_d  = skid_v_q || in_fire;
      skid_v_d = 1'b0;
    end else if (in_fire) begin
      skid_v_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      out_v_q  <= out_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_v_q) begin
        out_l_q <= skid_l_q;
        out_r_q <= skid_r_q;
        out_c_q <= skid_c_q;
      end else if (in_fire) begin
        out_l_q <= left_i.sample;
        out_r_q <= right_i.sample;
        out_c_q <= left_i.sat || right_i.sat;
      end
    end else if (in_fire) begin
      skid_l_q <= left_i.sample;
      skid_r_q <= right_i.sample;
      skid_c_q <= left_i.sat || right_i.sat;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = DATA_W'({out_r_q, out_l_q});
  assign m_axis_tuser  = out_c_q;

`ifndef NO_ASSERTIONS
  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid slot full while output empty");

  a_skid_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_v_q) |-> $past(out_v_q && !m_axis_tready))
    else $error("skid slot loaded without a stalled output");
`endif

endmodule
`default_nettype wire

/* rtl/stereo_width_pan_gain_core.sv */
// top level: register port, pan gain square roots, two channel lanes and merge
`default_nettype none
// Accepts one stereo pair per clock while s_axis_tready is high (low when the
// skid slot is full or a square root runs) and returns one result beat per
// pair in the same order, through four lane stages (cross-feed multiply, sum
// and magnitude, pan gain multiply, output gain multiply) and the output
// register. Full rate is set by the pipelined multipliers in each lane. A skid
// slot behind the output register keeps m_axis_tready off any combinational
// path to s_axis_tready. Each width, gain or pan write restarts two bit-serial
// square root units that recompute the pan gains, one result bit per cycle.
module stereo_width_pan_gain_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [swpg_pkg::DATA_W-1:0]       s_axis_tdata,  // left_in, right_in
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [swpg_pkg::DATA_W-1:0]       m_axis_tdata,  // left_out, right_out
  output logic                              m_axis_tuser,  // clipped
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [swpg_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [swpg_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [swpg_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                              pready
);
  import swpg_pkg::*;

  logic [WIDTH_BITS-1:0] width_q, width_d;
  logic [GAIN_BITS-1:0]  gain_q, gain_d;
  logic [PAN_BITS-1:0]   pan_q, pan_d;
  logic [PAN_BITS-1:0]   pan_clip;
  logic                  cfg_wr, sq_start;
  logic [1:0]            cfg_idx;

  logic [SQ_IN_W-1:0]  rad_l, rad_r;
  logic                busy_l, busy_r;
  logic [PG_BITS-1:0]  pg_l, pg_r;

  logic                   bypass;
  logic                   en, in_fire;
  logic [LANE_STAGES-1:0] valid_q;
  logic [SAMPLE_BITS-1:0] left_in, right_in;
  lane_res_t              res_l, res_r;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[CFG_ADDR_W-1:2];

  always_comb begin
    width_d  = width_q;
    gain_d   = gain_q;
    pan_d    = pan_q;
    sq_start = 1'b0;
    if (cfg_wr) begin
      case (cfg_idx)
        REG_WIDTH: begin
          width_d  = pwdata[WIDTH_BITS-1:0];
          sq_start = 1'b1;
        end
        REG_GAIN: begin
          gain_d   = pwdata[GAIN_BITS-1:0];
          sq_start = 1'b1;
        end
        REG_PAN: begin
          pan_d    = pwdata[PAN_BITS-1:0];
          sq_start = 1'b1;
        end
        default: begin
          sq_start = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= WIDTH_RESET;
      gain_q  <= GAIN_ONE;
      pan_q   <= PAN_RESET;
    end else begin
      width_q <= width_d;
      gain_q  <= gain_d;
      pan_q   <= pan_d;
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_WIDTH: prdata = CFG_DATA_W'(width_q);
      REG_GAIN:  prdata = CFG_DATA_W'(gain_q);
      REG_PAN:   prdata = CFG_DATA_W'(pan_q);
      default:   prdata = '0;
    endcase
  end

  // pan beyond right counts as full right
  assign pan_clip = (pan_d > PAN_ONE) ? PAN_ONE : pan_d;
  assign rad_l    = {PAN_ONE - pan_clip, {PAN_BITS{1'b0}}};
  assign rad_r    = {pan_clip, {PAN_BITS{1'b0}}};

  swpg_sqrt u_sqrt_l (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sq_start),
    .radicand_i (rad_l),
    .busy_o     (busy_l),
    .root_o     (pg_l)
  );

  swpg_sqrt u_sqrt_r (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sq_start),
    .radicand_i (rad_r),
    .busy_o     (busy_r),
    .root_o     (pg_r)
  );

  // near-unity settings pass samples straight through
  assign bypass = (pg_l >= PG_ONE - PG_TOL) && (pg_l <= PG_ONE + PG_TOL) &&
                  (pg_r >= PG_ONE - PG_TOL) && (pg_r <= PG_ONE + PG_TOL) &&
                  ((width_q == WIDTH_RESET) || (width_q == WIDTH_POS1) ||
                   (width_q == WIDTH_NEG1)) &&
                  (gain_q >= GAIN_ONE - GAIN_TOL) && (gain_q <= GAIN_ONE + GAIN_TOL);

  assign s_axis_tready = en && !busy_l && !busy_r;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign left_in       = s_axis_tdata[SAMPLE_BITS-1:0];
  assign right_in      = s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en) begin
      valid_q <= {valid_q[LANE_STAGES-2:0], in_fire};
    end
  end

  swpg_lane u_lane_l (
    .clk_i      (clk_i),
    .en_i       (en),
    .self_i     ($signed(left_in)),
    .other_i    ($signed(right_in)),
    .width_i    ($signed(width_q)),
    .pan_gain_i (pg_l),
    .gain_i     (gain_q),
    .bypass_i   (bypass),
    .res_o      (res_l)
  );

  swpg_lane u_lane_r (
    .clk_i      (clk_i),
    .en_i       (en),
    .self_i     ($signed(right_in)),
    .other_i    ($signed(left_in)),
    .width_i    ($signed(width_q)),
    .pan_gain_i (pg_r),
    .gain_i     (gain_q),
    .bypass_i   (bypass),
    .res_o      (res_r)
  );

  swpg_merge u_merge (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .pipe_valid_i  (valid_q[LANE_STAGES-1]),
    .left_i        (res_l),
    .right_i       (res_r),
    .en_o          (en),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

`ifndef NO_ASSERTIONS
  a_write_stalls_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_start |=> !s_axis_tready)
    else $error("input accepted while pan gains recompute");

  a_lanes_agree_bypass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bypass |-> (!res_l.sat && !res_r.sat))
    else $error("saturation flagged in pass-through mode");

  a_no_accept_when_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_l || busy_r) |-> !in_fire)
    else $error("beat accepted during square root run");
`endif

endmodule
`default_nettype wire

/* test/testbench.sv */
// self-checking testbench for the stereo width, pan and gain core
`default_nettype none
module testbench;
  import swpg_pkg::*;

  localparam int SB = SAMPLE_BITS;
  localparam int REG_UNUSED = 3;
  localparam int IDLE_PCT = 34;
  localparam int PHASE_PAIRS = 160;
  localparam int RANDOM_PHASES = 12;
  localparam int STEADY_PHASE = 5;
  localparam int DRAIN_CYCLES = 24;
  localparam int TIMEOUT_CYCLES = 400000;
  localparam longint unsigned SAMPLE_MAX = (64'd1 << (SB - 1)) - 64'd1;
  localparam longint GAIN_UNIT = longint'(GAIN_ONE);

  typedef struct packed {
    logic [SB-1:0] left_out;
    logic [SB-1:0] right_out;
    logic          clipped;
  } pair_result_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [DATA_W-1:0]     s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [DATA_W-1:0]     m_axis_tdata;
  logic                  m_axis_tuser;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  // local copy of the settings and the derived pan gains
  logic signed [WIDTH_BITS-1:0] width_q = WIDTH_RESET;
  logic [GAIN_BITS-1:0]         gain_q = GAIN_ONE;
  logic [PAN_BITS-1:0]          pan_q = PAN_RESET;
  logic [PG_BITS-1:0]           pan_gain_l = PG_ONE;
  logic [PG_BITS-1:0]           pan_gain_r = PG_ONE;

  pair_result_t pending_q[$];
  int  errors = 0;
  int  pairs_sent = 0;
  int  results_seen = 0;
  int  reg_writes = 0;
  int  clip_count = 0;
  bit  steady = 1'b0;

  stereo_width_pan_gain_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    m_axis_tready <= steady || ($urandom_range(99, 0) >= IDLE_PCT);
  end

  function automatic bit near(input longint unsigned a, input longint unsigned b,
                              input longint unsigned tol);
    return ((a > b) ? a - b : b - a) <= tol;
  endfunction

  function automatic logic [PG_BITS-1:0] sqrt_nearest(input longint unsigned n);
    longint unsigned root, trial;
    root = 0;
    for (int b = PG_BITS; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= n) root = trial;
    end
    if (n - root * root > root) root++;
    return root[PG_BITS-1:0];
  endfunction

  function automatic lane_res_t mix_lane(input longint own, input longint other,
                                         input logic [PG_BITS-1:0] pan_gain);
    longint acc;
    longint unsigned mag, t;
    lane_res_t res;
    acc = own * GAIN_UNIT + other * longint'(width_q);
    mag = (acc < 0) ? -acc : acc;
    t = (mag * pan_gain + (64'd1 << (ROUND1_SHIFT - 1))) >> ROUND1_SHIFT;
    t = (t * gain_q + (64'd1 << (ROUND2_SHIFT - 1))) >> ROUND2_SHIFT;
    res.sat = 1'b0;
    if (acc >= 0) begin
      res.sample = t[SB-1:0];
      if (t > SAMPLE_MAX) begin
        res.sat = 1'b1;
        res.sample = SAT_MAX;
      end
    end else if (t > SAMPLE_MAX + 1) begin
      res.sat = 1'b1;
      res.sample = SAT_MIN;
    end else begin
      t = 64'd0 - t;
      res.sample = t[SB-1:0];
    end
    return res;
  endfunction

  function automatic pair_result_t predict_pair(input logic signed [SB-1:0] l,
                                                input logic signed [SB-1:0] r);
    lane_res_t lo, ro;
    pair_result_t res;
    // near-unity settings pass the samples straight through
    if (near(pan_gain_l, PG_ONE, PG_TOL) && near(pan_gain_r, PG_ONE, PG_TOL) &&
        width_q >= -1 && width_q <= 1 && near(gain_q, GAIN_ONE, GAIN_TOL)) begin
      res.left_out = l;
      res.right_out = r;
      res.clipped = 1'b0;
      return res;
    end
    lo = mix_lane(longint'(l), longint'(r), pan_gain_l);
    ro = mix_lane(longint'(r), longint'(l), pan_gain_r);
    res.left_out = lo.sample;
    res.right_out = ro.sample;
    res.clipped = lo.sat | ro.sat;
    return res;
  endfunction

  function automatic logic [SB-1:0] rand_sample();
    case ($urandom_range(3, 0))
      0: return SB'($urandom_range(131072, 0) - 65536);
      1: return $urandom_range(1, 0) ? SAT_MAX : SAT_MIN;
      default: return SB'($urandom());
    endcase
  endfunction

  task automatic send_pair(input logic [SB-1:0] l, input logic [SB-1:0] r);
    while (!steady && $urandom_range(99, 0) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= DATA_W'({r, l});
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_q = {pending_q, predict_pair(l, r)};
    pairs_sent++;
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input int idx, input logic [CFG_DATA_W-1:0] value);
    longint unsigned p;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CFG_ADDR_W'(4 * idx);
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
    reg_writes++;
    case (idx)
      REG_WIDTH: width_q = value[WIDTH_BITS-1:0];
      REG_GAIN:  gain_q = value[GAIN_BITS-1:0];
      REG_PAN:   pan_q = value[PAN_BITS-1:0];
      default:   return;
    endcase
    // pan positions past full right act as full right
    p = (pan_q > PAN_ONE) ? PAN_ONE : pan_q;
    pan_gain_l = sqrt_nearest(2 * (longint'(PAN_ONE) - p) * longint'(PAN_ONE));
    pan_gain_r = sqrt_nearest(2 * p * longint'(PAN_ONE));
  endtask

  task automatic set_mix(input logic [WIDTH_BITS-1:0] w, input logic [GAIN_BITS-1:0] g,
                         input logic [PAN_BITS-1:0] p);
    settle();
    write_reg(REG_WIDTH, CFG_DATA_W'(w));
    write_reg(REG_GAIN, CFG_DATA_W'(g));
    write_reg(REG_PAN, CFG_DATA_W'(p));
  endtask

  task automatic send_edges();
    send_pair(SAT_MAX, SAT_MAX);
    send_pair(SAT_MIN, SAT_MIN);
    send_pair(SAT_MAX, SAT_MIN);
    send_pair(SAT_MIN, SAT_MAX);
    send_pair('0, '1);
  endtask

  task automatic test_reset_passthrough();
    send_edges();
  endtask

  task automatic test_bypass_tolerance();
    set_mix(WIDTH_NEG1, GAIN_ONE + 16'd1, PAN_RESET + 17'd2);
    send_edges();
    settle();
    write_reg(REG_GAIN, CFG_DATA_W'(GAIN_ONE + 16'd2));
    send_pair(SAT_MAX, SAT_MIN);
    send_pair(rand_sample(), rand_sample());
  endtask

  task automatic test_extreme_settings();
    set_mix(16'h7fff, 16'hffff, '0);
    send_edges();
    set_mix(16'h8000, '0, PAN_ONE);
    send_edges();
  endtask

  task automatic test_pan_past_right();
    set_mix(WIDTH_RESET, GAIN_ONE, {PAN_BITS{1'b1}});
    write_reg(REG_UNUSED, $urandom());
    send_pair(SAT_MAX, SAT_MAX);
    send_pair(SAT_MIN, SAT_MIN);
    send_pair(rand_sample(), rand_sample());
  endtask

  task automatic test_random_phases();
    logic [WIDTH_BITS-1:0] w;
    logic [GAIN_BITS-1:0]  g;
    logic [PAN_BITS-1:0]   p;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case ($urandom_range(3, 0))
        0: w = WIDTH_BITS'($urandom());
        1: w = WIDTH_BITS'($urandom_range(8192, 0) - 4096);
        2: w = WIDTH_BITS'($urandom_range(2, 0) - 1);
        default: w = WIDTH_RESET;
      endcase
      case ($urandom_range(2, 0))
        0: g = GAIN_BITS'($urandom());
        1: g = GAIN_BITS'(GAIN_ONE + $urandom_range(2, 0) - 1);
        default: g = GAIN_BITS'($urandom_range(24576, 8192));
      endcase
      case ($urandom_range(5, 0))
        0: p = PAN_BITS'(PAN_RESET + $urandom_range(16, 0) - 8);
        1: p = PAN_BITS'($urandom_range(131071, 65537));
        2: p = $urandom_range(1, 0) ? PAN_ONE : '0;
        default: p = PAN_BITS'($urandom_range(65536, 0));
      endcase
      set_mix(w, g, p);
      if ($urandom_range(3, 0) == 0) write_reg(REG_UNUSED, $urandom());
      steady = (phase == STEADY_PHASE);
      for (int i = 0; i < PHASE_PAIRS; i++) send_pair(rand_sample(), rand_sample());
    end
    steady = 1'b0;
  endtask

  always @(posedge clk_i) begin
    pair_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (pending_q.size() == 0) begin
        $error("unexpected result beat: left_out %0d right_out %0d",
               $signed(m_axis_tdata[SB-1:0]), $signed(m_axis_tdata[2*SB-1:SB]));
        errors++;
      end else begin
        want = pending_q.pop_front();
        if (want.clipped) clip_count++;
        if (m_axis_tdata[SB-1:0] !== want.left_out) begin
          $error("left_out: expected %0d, got %0d", $signed(want.left_out),
                 $signed(m_axis_tdata[SB-1:0]));
          errors++;
        end
        if (m_axis_tdata[2*SB-1:SB] !== want.right_out) begin
          $error("right_out: expected %0d, got %0d", $signed(want.right_out),
                 $signed(m_axis_tdata[2*SB-1:SB]));
          errors++;
        end
        if (m_axis_tuser !== want.clipped) begin
          $error("clipped: expected %0b, got %0b", want.clipped, m_axis_tuser);
          errors++;
        end
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_passthrough();
    test_bypass_tolerance();
    test_extreme_settings();
    test_pan_past_right();
    test_random_phases();
    settle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("testbench: %0d stereo pairs sent, %0d result beats checked, %0d register writes",
             pairs_sent, results_seen, reg_writes);
    $display("testbench: %0d results clipped, %0d mismatches", clip_count, errors);
    if (errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_CYCLES * 12);
    $display("testbench: timed out with %0d results outstanding", pending_q.size());
    $display("testbench: done, errors");
    $finish;
  end

endmodule
`default_nettype wire

/* stereo_width_pan_gain_core.f */
rtl/swpg_pkg.sv
rtl/swpg_sqrt.sv
rtl/swpg_lane.sv
rtl/swpg_merge.sv
rtl/stereo_width_pan_gain_core.sv
test/testbench.sv
